FILE: hdl/losb_pkg.sv
// Package for the line-of-sight box test: widths, codes and shared types.
// No dependencies.
package losb_pkg;

   localparam int MaxBoxesDefault  = 64;
   localparam int CoordBitsDefault = 24;
   localparam int IndexBits        = 6;
   localparam int CountBits        = 7;
   localparam int ThinBits         = 23;
   localparam int CsrIndexBits     = 1;
   localparam logic [ThinBits-1:0] ThinReset = 23'd38;

   localparam logic [CsrIndexBits-1:0] CSR_BOX_COUNT   = 1'b0;
   localparam logic [CsrIndexBits-1:0] CSR_THIN_HEIGHT = 1'b1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_AXIS,
      BK_MUL,
      BK_CMP,
      BK_FINAL,
      BK_DONE
   } bk_state_type;

endpackage

FILE: hdl/losb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module losb_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/losb_queue.sv
// Two-entry word queue between the front and back parts.
// Depends on nothing but its parameter.
module losb_queue #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);
   logic [Width-1:0] slot_ff [2];
   logic [Width-1:0] slot_in [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in[wr_ff] = in_data;
      end
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop && cnt_ff == 2'd1) |=> cnt_ff == 2'd2)
      else $error("queue count lost a push");
endmodule

FILE: hdl/losb_front.sv
// Front part: accepts request words, stores box loads, forwards queries.
// Depends on losb_pkg and losb_ram.
module losb_front
   import losb_pkg::*;
#(
   parameter int MaxBoxes  = MaxBoxesDefault,
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [IndexBits-1:0]        req_box_index,
   input  logic signed [CoordBits-1:0] req_first_x,
   input  logic signed [CoordBits-1:0] req_first_y,
   input  logic signed [CoordBits-1:0] req_first_z,
   input  logic signed [CoordBits-1:0] req_second_x,
   input  logic signed [CoordBits-1:0] req_second_y,
   input  logic signed [CoordBits-1:0] req_second_z,
   output logic                        q_valid,
   input  logic                        q_ready,
   input  logic                        back_busy,
   input  logic [$clog2(MaxBoxes)-1:0] rd_addr,
   output logic [6*CoordBits-1:0]      rd_box
);
   localparam int AddrBits = $clog2(MaxBoxes);
   localparam int IdxW = ((IndexBits > AddrBits) ? IndexBits : AddrBits) + 1;
   logic load_ok, wr_en;
   logic [IdxW-1:0] idx_ext;

   assign idx_ext   = IdxW'(req_box_index);
   assign load_ok   = (idx_ext < IdxW'(MaxBoxes));
   assign req_ready = (req_action == ACT_LOAD) ? !back_busy : q_ready;
   assign q_valid   = req_valid && (req_action == ACT_QUERY);
   assign wr_en     = req_valid && req_ready && (req_action == ACT_LOAD) && load_ok;

   losb_ram #(.Width(6*CoordBits), .Depth(MaxBoxes)) u_boxes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AddrBits'(req_box_index)),
      .wr_data ({req_second_z, req_second_y, req_second_x,
                 req_first_z, req_first_y, req_first_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_box)
   );
endmodule

FILE: hdl/losb_back.sv
// Back part: walks stored boxes for one query with an exact slab test, skipping thin boxes.
// Depends on losb_pkg.
module losb_back
   import losb_pkg::*;
#(
   parameter int MaxBoxes  = MaxBoxesDefault,
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  logic [6*CoordBits-1:0]      q_data,
   input  logic [CountBits-1:0]        box_count,
   input  logic [ThinBits-1:0]         thin_height,
   output logic [$clog2(MaxBoxes)-1:0] rd_addr,
   input  logic [6*CoordBits-1:0]      rd_box,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_line_clear,
   output logic [IndexBits-1:0]        rsp_blocker_index
);
   localparam int AddrBits = $clog2(MaxBoxes);
   localparam int CntW = AddrBits + 1;
   localparam int DW = CoordBits + 2;
   localparam int PW = 2 * DW;

   bk_state_type state_ff, state_in;
   logic signed [CoordBits-1:0] o_ff [3], o_in [3];
   logic signed [DW-1:0] d_ff [3], d_in [3];
   logic [CntW-1:0] idx_ff, idx_in, lim_ff, lim_in;
   logic [1:0] ax_ff, ax_in;
   logic [1:0] ph_ff, ph_in;
   logic signed [DW-1:0] n0_ff, n0_in, d0_ff, d0_in, n1_ff, n1_in, d1_ff, d1_in;
   logic signed [DW-1:0] en_ff, en_in, ex_ff, ex_in, den_ff, den_in;
   logic [6*CoordBits-1:0] box_ff, box_in;
   logic signed [PW-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic clear_ff, clear_in;
   logic [IndexBits-1:0] blk_ff, blk_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [CoordBits-1:0] lo, hi, ok, bmin_y, bmax_y;
   logic signed [DW-1:0] dk, a, b, h;
   logic signed [DW-1:0] mul_a, mul_b, mul_c, mul_d;
   logic [CntW-1:0] cnt_ext;

   always_comb begin
      lo = box_ff[ax_ff*CoordBits +: CoordBits];
      hi = box_ff[(ax_ff+2'd3)*CoordBits +: CoordBits];
      ok = o_ff[ax_ff];
      dk = d_ff[ax_ff];
      bmin_y = box_ff[CoordBits +: CoordBits];
      bmax_y = box_ff[4*CoordBits +: CoordBits];
      h = DW'(bmax_y) - DW'(bmin_y);
      a = dk[DW-1] ? DW'(ok) - DW'(lo) : DW'(lo) - DW'(ok);
      b = dk[DW-1] ? DW'(ok) - DW'(hi) : DW'(hi) - DW'(ok);
      cnt_ext = (CntW > CountBits) ? CntW'(box_count)
                : ((box_count > CountBits'(MaxBoxes)) ? CntW'(MaxBoxes) : CntW'(box_count));
   end

   // Cross products for ratio compare: (an * bd) vs (bn * ad), ad and bd positive.
   always_comb begin
      mul_a = en_ff; mul_b = d0_ff; mul_c = n0_ff; mul_d = den_ff;
      unique case (ph_ff)
         2'd0: begin
            mul_a = en_ff; mul_b = d0_ff; mul_c = n0_ff; mul_d = den_ff;
         end
         2'd1: begin
            mul_a = ex_ff; mul_b = d1_ff; mul_c = n1_ff; mul_d = den_ff;
         end
         default: begin
            mul_a = n0_ff; mul_b = d1_ff; mul_c = n1_ff; mul_d = d0_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      o_in = o_ff; d_in = d_ff;
      idx_in = idx_ff; lim_in = lim_ff; ax_in = ax_ff; ph_in = ph_ff;
      n0_in = n0_ff; d0_in = d0_ff; n1_in = n1_ff; d1_in = d1_ff;
      en_in = en_ff; ex_in = ex_ff; den_in = den_ff;
      box_in = box_ff;
      pa_in = PW'(mul_a) * PW'(mul_b);
      pb_in = PW'(mul_c) * PW'(mul_d);
      clear_in = clear_ff; blk_in = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      q_ready = 1'b0;
      rd_addr = AddrBits'(idx_ff);
      unique case (state_ff)
         BK_IDLE: begin
            q_ready = !rsp_valid_ff;
            if (q_valid && !rsp_valid_ff) begin
               for (int k = 0; k < 3; k++) begin
                  o_in[k] = q_data[k*CoordBits +: CoordBits];
                  d_in[k] = DW'($signed(q_data[(k+3)*CoordBits +: CoordBits]))
                            - DW'($signed(q_data[k*CoordBits +: CoordBits]));
               end
               idx_in = '0;
               lim_in = cnt_ext;
               clear_in = 1'b1;
               blk_in = '0;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if ((d_ff[0] == '0 && d_ff[1] == '0 && d_ff[2] == '0) || idx_ff >= lim_ff) begin
               state_in = BK_DONE;
            end else begin
               state_in = BK_AXIS;
               ax_in = 2'd0;
               n0_in = '0; d0_in = DW'(1); n1_in = DW'(1); d1_in = DW'(1);
               ph_in = 2'd3;
            end
         end
         BK_AXIS: begin
            if (ax_ff == 2'd0 && ph_ff == 2'd3) begin
               box_in = rd_box;
               ph_in = 2'd0;
            end else if (ax_ff == 2'd0 && ph_ff == 2'd0 && h < $signed(DW'(thin_height))) begin
               idx_in = idx_ff + 1'b1;
               state_in = BK_READ;
            end else if (ax_ff == 2'd3) begin
               ph_in = 2'd2;
               state_in = BK_MUL;
            end else if (dk == '0) begin
               if (ok < lo || ok > hi) begin
                  idx_in = idx_ff + 1'b1;
                  state_in = BK_READ;
               end else begin
                  ax_in = ax_ff + 1'b1;
               end
            end else begin
               den_in = dk[DW-1] ? -dk : dk;
               en_in = (a < b) ? a : b;
               ex_in = (a < b) ? b : a;
               ph_in = 2'd0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_CMP;
         end
         BK_CMP: begin
            unique case (ph_ff)
               2'd0: begin
                  if (pa_ff > pb_ff) begin
                     n0_in = en_ff; d0_in = den_ff;
                  end
                  ph_in = 2'd1;
                  state_in = BK_MUL;
               end
               2'd1: begin
                  if (pa_ff < pb_ff) begin
                     n1_in = ex_ff; d1_in = den_ff;
                  end
                  ax_in = ax_ff + 1'b1;
                  state_in = BK_AXIS;
               end
               default: begin
                  state_in = BK_FINAL;
               end
            endcase
         end
         BK_FINAL: begin
            if (pa_ff <= pb_ff) begin
               clear_in = 1'b0;
               blk_in = IndexBits'(idx_ff);
               state_in = BK_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = BK_READ;
            end
         end
         BK_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      o_ff <= o_in; d_ff <= d_in;
      lim_ff <= lim_in; ax_ff <= ax_in; ph_ff <= ph_in;
      n0_ff <= n0_in; d0_ff <= d0_in; n1_ff <= n1_in; d1_ff <= d1_in;
      en_ff <= en_in; ex_ff <= ex_in; den_ff <= den_in;
      box_ff <= box_in;
      pa_ff <= pa_in; pb_ff <= pb_in;
      clear_ff <= clear_in; blk_ff <= blk_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy = (state_ff != BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_line_clear = clear_ff;
   assign rsp_blocker_index = blk_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_clear) |-> rsp_blocker_index == '0)
      else $error("clear result with nonzero blocker");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_IDLE) |-> !q_ready)
      else $error("query taken while busy");
endmodule

FILE: hdl/line_of_sight_box_test.sv
// A load is written into the box table when it is accepted. A query walks the stored boxes in
// order; a thin box is dropped after its height check, and an axis parallel to the line skips
// its ratio compares. One query is walked at a time, later ones wait in the queue. The shared
// multiplier pair does two ratio compares per non-parallel axis and a final order check per box.
// Loads wait while a query is queued or being walked. Reset clears control state and sets
// box_count to 0, thin_height to 38; box table contents are undefined until loaded.
module line_of_sight_box_test
   import losb_pkg::*;
#(
   parameter int MaxBoxes  = MaxBoxesDefault,
   parameter int CoordBits = CoordBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [IndexBits-1:0]        req_box_index,
   input  logic signed [CoordBits-1:0] req_first_x,
   input  logic signed [CoordBits-1:0] req_first_y,
   input  logic signed [CoordBits-1:0] req_first_z,
   input  logic signed [CoordBits-1:0] req_second_x,
   input  logic signed [CoordBits-1:0] req_second_y,
   input  logic signed [CoordBits-1:0] req_second_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_line_clear,
   output logic [IndexBits-1:0]        rsp_blocker_index,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CsrIndexBits-1:0]     csr_index,
   input  logic [31:0]                 csr_data
);
   localparam int AddrBits = $clog2(MaxBoxes);
   localparam int QW = 6 * CoordBits;

   logic [CountBits-1:0] box_count_ff;
   logic [ThinBits-1:0]  thin_height_ff;
   logic                 fq_valid, fq_ready, bq_valid, bq_ready;
   logic [QW-1:0]        bq_data, rd_box;
   logic [AddrBits-1:0]  rd_addr;
   logic                 bk_busy, back_busy;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff   <= '0;
         thin_height_ff <= ThinReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOX_COUNT:   box_count_ff   <= csr_data[CountBits-1:0];
            CSR_THIN_HEIGHT: thin_height_ff <= csr_data[ThinBits-1:0];
            default: ;
         endcase
      end
   end

   assign back_busy = bq_valid || bk_busy;

   losb_front #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_box_index (req_box_index),
      .req_first_x   (req_first_x),
      .req_first_y   (req_first_y),
      .req_first_z   (req_first_z),
      .req_second_x  (req_second_x),
      .req_second_y  (req_second_y),
      .req_second_z  (req_second_z),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .back_busy     (back_busy),
      .rd_addr       (rd_addr),
      .rd_box        (rd_box)
   );

   losb_queue #(.Width(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   ({req_second_z, req_second_y, req_second_x,
                   req_first_z, req_first_y, req_first_x}),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   losb_back #(.MaxBoxes(MaxBoxes), .CoordBits(CoordBits)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (bq_valid),
      .q_ready           (bq_ready),
      .q_data            (bq_data),
      .box_count         (box_count_ff),
      .thin_height       (thin_height_ff),
      .rd_addr           (rd_addr),
      .rd_box            (rd_box),
      .busy              (bk_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_clear    (rsp_line_clear),
      .rsp_blocker_index (rsp_blocker_index)
   );
endmodule
